>>> hdl/frr_pkg.sv
// frr_pkg: shared types and constants for the fragment reorder receiver.
// Used by every module under hdl/; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package frr_pkg;

    localparam int SEQ_W          = 16;
    localparam int LEN_W          = 16;
    localparam int HANDLE_W       = 16;
    localparam int CFG_W          = 6;
    localparam int EXP_W          = 6;
    localparam int MAX_FRAGS_DEF  = 32;
    localparam logic [CFG_W-1:0] TOTAL_RESET = 6'd32;

    typedef enum logic [1:0] {
        EV_DELIVER = 2'd0,
        EV_ACK     = 2'd1,
        EV_REPORT  = 2'd2,
        EV_REJECT  = 2'd3
    } event_kind_t;

    typedef struct packed {
        logic [SEQ_W-1:0]    frag_seq;
        logic [LEN_W-1:0]    frag_len;
        logic [HANDLE_W-1:0] payload_handle;
    } frag_t;

    typedef struct packed {
        event_kind_t         event_kind;
        logic [SEQ_W-1:0]    event_seq;
        logic [LEN_W-1:0]    event_len;
        logic [HANDLE_W-1:0] event_handle;
        logic [EXP_W-1:0]    expected_now;
        logic                last;
    } result_t;

    // Contents of one reorder slot
    typedef struct packed {
        logic [LEN_W-1:0]    len;
        logic [HANDLE_W-1:0] handle;
    } slot_t;

    // Slot memory request; write and read never happen in the same cycle
    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic [EXP_W-1:0] addr;
        slot_t            wr_data;
    } slot_req_t;

    // Shared compare/increment unit outputs
    typedef struct packed {
        logic             lt;
        logic             eq;
        logic [SEQ_W-1:0] inc;
    } cmp_res_t;

endpackage

`default_nettype wire

>>> hdl/frr_cmp.sv
// frr_cmp: shared compare and increment unit, reused by the sequencer
// for range, order and flush checks. Depends on frr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frr_cmp
    import frr_pkg::*;
(
    input  wire logic [SEQ_W-1:0] op_a,
    input  wire logic [SEQ_W-1:0] op_b,
    output cmp_res_t              res
);

    always_comb
    begin
        res.lt  = (op_a < op_b);
        res.eq  = (op_a == op_b);
        res.inc = op_a + SEQ_W'(1);
    end

endmodule

`default_nettype wire

>>> hdl/frr_slot_mem.sv
// frr_slot_mem: length/handle storage for buffered fragments, one port,
// registered read. Depends on frr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frr_slot_mem
    import frr_pkg::*;
#(
    parameter int DEPTH = MAX_FRAGS_DEF
)
(
    input  wire logic      clk,
    input  wire slot_req_t req,
    output slot_t          rd_data
);

    localparam int IDX_W = $clog2(DEPTH);

    slot_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr[IDX_W-1:0]] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.addr[IDX_W-1:0]];
        end
    end

endmodule

`default_nettype wire

>>> hdl/frr_ctrl.sv
// frr_ctrl: sequencer for the reorder receiver; holds the expected number,
// the slot presence map and the total register. Depends on frr_pkg, frr_cmp.
`timescale 1ns / 1ps
`default_nettype none

module frr_ctrl
    import frr_pkg::*;
#(
    parameter int MAX_FRAGMENTS = MAX_FRAGS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire frag_t            frag,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire slot_t            rd_data,
    output slot_req_t             req,
    output logic                  busy,
    output logic                  result_valid,
    output result_t               result
);

    localparam int IDX_W = $clog2(MAX_FRAGMENTS);
    localparam logic [EXP_W-1:0] MAX_TOTAL = EXP_W'(MAX_FRAGMENTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RANGE,
        S_ORDER,
        S_ACK,
        S_PROBE,
        S_FETCH
    } state_t;

    state_t                   state_reg;
    logic [EXP_W-1:0]         expected_reg;
    logic [EXP_W-1:0]         total_reg;
    logic [EXP_W-1:0]         total_eff_reg;
    logic [MAX_FRAGMENTS-1:0] present_reg;
    logic                     valid_reg;
    frag_t                    item_reg;
    result_t                  pending_reg;
    result_t                  result_reg;

    logic [SEQ_W-1:0] op_a;
    logic [SEQ_W-1:0] op_b;
    cmp_res_t         cmp;
    logic [EXP_W-1:0] total_clamped;
    logic [IDX_W-1:0] seq_idx;
    logic [IDX_W-1:0] exp_idx;
    logic             slot_free;
    logic             more;
    logic             ahead;

    frr_cmp u_cmp (
        .op_a (op_a),
        .op_b (op_b),
        .res  (cmp)
    );

    assign seq_idx   = item_reg.frag_seq[IDX_W-1:0];
    assign exp_idx   = expected_reg[IDX_W-1:0];
    assign slot_free = !present_reg[seq_idx];
    // flush continues while expected < total and its slot is filled
    assign more      = cmp.lt && present_reg[exp_idx];
    assign ahead     = !cmp.lt && !cmp.eq;

    always_comb
    begin
        if (total_reg == '0)
        begin
            total_clamped = EXP_W'(1);
        end
        else if (total_reg > MAX_TOTAL)
        begin
            total_clamped = MAX_TOTAL;
        end
        else
        begin
            total_clamped = total_reg;
        end
    end

    always_comb
    begin
        unique case (state_reg)
            S_RANGE:
            begin
                op_a = item_reg.frag_seq;
                op_b = SEQ_W'(total_eff_reg);
            end
            S_ORDER:
            begin
                op_a = item_reg.frag_seq;
                op_b = SEQ_W'(expected_reg);
            end
            S_ACK, S_PROBE, S_FETCH:
            begin
                op_a = SEQ_W'(expected_reg);
                op_b = SEQ_W'(total_eff_reg);
            end
            default:
            begin
                op_a = item_reg.frag_seq;
                op_b = SEQ_W'(total_eff_reg);
            end
        endcase
    end

    always_comb
    begin
        req.wr_en          = (state_reg == S_ORDER) && ahead && slot_free;
        req.rd_en          = (state_reg == S_PROBE) && more;
        req.addr           = (state_reg == S_ORDER) ? item_reg.frag_seq[EXP_W-1:0]
                                                    : expected_reg;
        req.wr_data.len    = item_reg.frag_len;
        req.wr_data.handle = item_reg.payload_handle;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            expected_reg  <= '0;
            total_reg     <= TOTAL_RESET;
            total_eff_reg <= TOTAL_RESET;
            present_reg   <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            if (cfg_we)
            begin
                total_reg <= cfg_data;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        total_eff_reg <= total_clamped;
                        state_reg     <= S_RANGE;
                    end
                end
                S_RANGE:
                begin
                    if (!cmp.lt)
                    begin
                        valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_ORDER;
                    end
                end
                S_ORDER:
                begin
                    priority if (cmp.lt)
                    begin
                        // stale duplicate: dropped without a result
                        state_reg <= S_IDLE;
                    end
                    else if (cmp.eq)
                    begin
                        valid_reg <= 1'b1;
                        state_reg <= S_ACK;
                    end
                    else
                    begin
                        if (slot_free)
                        begin
                            present_reg[seq_idx] <= 1'b1;
                        end
                        valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_ACK:
                begin
                    expected_reg <= cmp.inc[EXP_W-1:0];
                    state_reg    <= S_PROBE;
                end
                S_PROBE:
                begin
                    valid_reg <= 1'b1;
                    state_reg <= more ? S_FETCH : S_IDLE;
                end
                S_FETCH:
                begin
                    present_reg[exp_idx] <= 1'b0;
                    expected_reg         <= cmp.inc[EXP_W-1:0];
                    state_reg            <= S_PROBE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Payload: captured transaction, held result and output result
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_reg <= frag;
                end
            end
            S_RANGE:
            begin
                result_reg.event_kind   <= EV_REJECT;
                result_reg.event_seq    <= item_reg.frag_seq;
                result_reg.event_len    <= '0;
                result_reg.event_handle <= '0;
                result_reg.expected_now <= expected_reg;
                result_reg.last         <= 1'b1;
            end
            S_ORDER:
            begin
                result_reg.event_seq <= item_reg.frag_seq;
                if (cmp.eq)
                begin
                    result_reg.event_kind   <= EV_DELIVER;
                    result_reg.event_len    <= item_reg.frag_len;
                    result_reg.event_handle <= item_reg.payload_handle;
                    result_reg.expected_now <= item_reg.frag_seq[EXP_W-1:0];
                    result_reg.last         <= 1'b0;
                end
                else
                begin
                    result_reg.event_kind   <= EV_REPORT;
                    result_reg.event_len    <= '0;
                    result_reg.event_handle <= '0;
                    result_reg.expected_now <= expected_reg;
                    result_reg.last         <= 1'b1;
                end
            end
            S_ACK:
            begin
                pending_reg.event_kind   <= EV_ACK;
                pending_reg.event_seq    <= item_reg.frag_seq;
                pending_reg.event_len    <= '0;
                pending_reg.event_handle <= '0;
                pending_reg.expected_now <= cmp.inc[EXP_W-1:0];
                pending_reg.last         <= 1'b0;
            end
            S_PROBE:
            begin
                // held result goes out once we know whether another follows
                result_reg.event_kind   <= pending_reg.event_kind;
                result_reg.event_seq    <= pending_reg.event_seq;
                result_reg.event_len    <= pending_reg.event_len;
                result_reg.event_handle <= pending_reg.event_handle;
                result_reg.expected_now <= pending_reg.expected_now;
                result_reg.last         <= !more;
            end
            S_FETCH:
            begin
                pending_reg.event_kind   <= EV_DELIVER;
                pending_reg.event_seq    <= SEQ_W'(expected_reg);
                pending_reg.event_len    <= rd_data.len;
                pending_reg.event_handle <= rd_data.handle;
                pending_reg.expected_now <= expected_reg;
                pending_reg.last         <= 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

>>> hdl/fragment_reorder_receiver.sv
// Fragment reorder receiver, top level: sequencer plus slot memory.
// Depends on frr_pkg, frr_ctrl, frr_slot_mem.
//
// Takes one fragment descriptor when start is high and busy is low, then
// stays busy while one shared compare/increment unit walks the checks in
// turn: S_RANGE ends an out-of-range descriptor, S_ORDER a stale duplicate
// or an out-of-order report, and an in-order one goes on through S_ACK,
// S_PROBE and an S_FETCH/S_PROBE pair per buffered fragment released, S_FETCH
// taking the registered read of the slot memory; no new descriptor is taken
// while busy. The final result sits on the ports in the first idle cycle.
// Results appear on result with result_valid high for exactly one cycle
// each, in order, and last marks the final one for the descriptor; the
// receiver must take every result as it comes, there is no back-pressure.
// total_fragments must be written through cfg_we/cfg_data only while the
// block is idle; the block does not enforce this. 0 acts as 1 and values
// above MAX_FRAGMENTS act as MAX_FRAGMENTS. The presence map clears at reset.
`timescale 1ns / 1ps
`default_nettype none

module fragment_reorder_receiver
    import frr_pkg::*;
#(
    parameter int MAX_FRAGMENTS = MAX_FRAGS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire frag_t            frag,
    output logic                  busy,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_data,
    output logic                  result_valid,
    output result_t               result
);

    slot_req_t slot_req;
    slot_t     slot_rd;

    frr_ctrl #(
        .MAX_FRAGMENTS (MAX_FRAGMENTS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .frag         (frag),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .rd_data      (slot_rd),
        .req          (slot_req),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    frr_slot_mem #(
        .DEPTH (MAX_FRAGMENTS)
    ) u_slot_mem (
        .clk     (clk),
        .req     (slot_req),
        .rd_data (slot_rd)
    );

endmodule

`default_nettype wire

>>> hdl/frr_checker.sv
// frr_checker: port-level assertions for the fragment reorder receiver,
// bound to the top level. Depends on frr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frr_checker
    import frr_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire logic    result_valid,
    input wire result_t result
);

    // an accepted transaction always occupies the block
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted transaction");

    // nothing follows the final result of a transaction back to back
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |=> !result_valid)
        else $error("result right after final result");

    // more results pending means the block is still working
    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> busy)
        else $error("idle with results still pending");

    // acknowledge advances expected past the acknowledged fragment
    a_ack_expect: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.event_kind == EV_ACK |->
            result.expected_now == EXP_W'(result.event_seq + SEQ_W'(1)))
        else $error("acknowledge carries wrong expected number");

    // an acknowledge follows the delivery of its fragment, past the S_ACK and S_PROBE states
    a_deliver_ack: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.event_kind == EV_ACK |->
            $past(result_valid, 2) && $past(result.event_kind, 2) == EV_DELIVER)
        else $error("acknowledge without preceding delivery");

endmodule

bind fragment_reorder_receiver frr_checker u_frr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

`default_nettype wire

>>> tb/sv/fragment_reorder_receiver_tb.sv
// Self-checking testbench for fragment_reorder_receiver: directed and random
// fragment descriptors checked against an in-bench reorder predictor.
// Depends on frr_pkg and the fragment_reorder_receiver RTL.
`timescale 1ns / 1ps

module fragment_reorder_receiver_tb;
    import frr_pkg::*;

    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 10;    // idle gap before a total_fragments write
    localparam int DRAIN_CYCLES  = 100;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 110;
    localparam int RANDOM_ITEMS  = 3 * PHASE_ITEMS;
    localparam int DIRECTED_NEXT = 9;     // next sequence number after the directed part

    typedef struct {
        bit               is_cfg;
        logic [CFG_W-1:0] cfg_val;
        frag_t            f;
    } backlog_entry_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    frag_t            frag = '0;
    logic             busy;
    logic             cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             result_valid;
    result_t          result;

    backlog_entry_t frag_backlog[$];
    result_t        pending_events[$];
    int             sender_gap_pct = 11;
    int             quiet_cycles = 0;
    int             stall_cycles = 0;
    int             err_count = 0;

    // Reorder state as the block should hold it
    logic [CFG_W-1:0]    total_reg = TOTAL_RESET;
    int unsigned         next_seq = 0;
    bit                  held [MAX_FRAGS_DEF];
    logic [LEN_W-1:0]    held_len [MAX_FRAGS_DEF];
    logic [HANDLE_W-1:0] held_handle [MAX_FRAGS_DEF];

    fragment_reorder_receiver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .frag         (frag),
        .busy         (busy),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    always #5 clk = ~clk;

    function automatic int unsigned eff_total();
        if (total_reg == 0)
            return 1;
        if (total_reg > MAX_FRAGS_DEF)
            return MAX_FRAGS_DEF;
        return total_reg;
    endfunction

    function automatic void push_event(event_kind_t kind, logic [SEQ_W-1:0] seq,
                                       logic [LEN_W-1:0] len, logic [HANDLE_W-1:0] hnd,
                                       logic [EXP_W-1:0] exp_now);
        result_t r;
        r.event_kind   = kind;
        r.event_seq    = seq;
        r.event_len    = len;
        r.event_handle = hnd;
        r.expected_now = exp_now;
        r.last         = 1'b0;
        pending_events.push_back(r);
    endfunction

    function automatic void reorder_predict(frag_t f);
        int unsigned win;
        int unsigned s;
        win = eff_total();
        s = f.frag_seq;
        if (s >= win) begin
            push_event(EV_REJECT, f.frag_seq, '0, '0, EXP_W'(next_seq));
        end else if (s > next_seq) begin
            // an occupied slot keeps its first descriptor
            if (!held[s]) begin
                held[s]        = 1'b1;
                held_len[s]    = f.frag_len;
                held_handle[s] = f.payload_handle;
            end
            push_event(EV_REPORT, f.frag_seq, '0, '0, EXP_W'(next_seq));
        end else if (s == next_seq) begin
            push_event(EV_DELIVER, f.frag_seq, f.frag_len, f.payload_handle, EXP_W'(s));
            next_seq = s + 1;
            push_event(EV_ACK, f.frag_seq, '0, '0, EXP_W'(next_seq));
            while (next_seq < win && held[next_seq]) begin
                push_event(EV_DELIVER, SEQ_W'(next_seq), held_len[next_seq],
                           held_handle[next_seq], EXP_W'(next_seq));
                held[next_seq] = 1'b0;
                next_seq++;
            end
        end else begin
            return;    // stale duplicate: dropped
        end
        pending_events[pending_events.size() - 1].last = 1'b1;
    endfunction

    task automatic flag_error(input string msg);
        err_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic queue_frag(input logic [SEQ_W-1:0] s, input logic [LEN_W-1:0] l,
                              input logic [HANDLE_W-1:0] h);
        backlog_entry_t e;
        e.is_cfg  = 1'b0;
        e.cfg_val = '0;
        e.f       = '{frag_seq: s, frag_len: l, payload_handle: h};
        frag_backlog.push_back(e);
    endtask

    task automatic queue_total(input logic [CFG_W-1:0] v);
        backlog_entry_t e;
        e.is_cfg  = 1'b1;
        e.cfg_val = v;
        e.f       = '0;
        frag_backlog.push_back(e);
    endtask

    task automatic drain_backlog();
        while (frag_backlog.size() != 0)
            @(negedge clk);
    endtask

    // Driver: one descriptor per start/busy handshake, register writes only when idle
    always @(posedge clk or negedge rst_n) begin : drive_frags
        logic hold;
        logic nxt_start;
        logic nxt_we;
        if (!rst_n) begin
            start    <= 1'b0;
            frag     <= '0;
            cfg_we   <= 1'b0;
            cfg_data <= '0;
        end else begin
            nxt_start = 1'b0;
            nxt_we    = 1'b0;
            hold      = start && busy;
            if (!start && !busy && !result_valid && !cfg_we && pending_events.size() == 0)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            if (start && !busy) begin
                reorder_predict(frag);
                void'(frag_backlog.pop_front());
            end
            if (!hold && frag_backlog.size() != 0) begin
                if (frag_backlog[0].is_cfg) begin
                    if (quiet_cycles >= SETTLE_CYCLES) begin
                        nxt_we       = 1'b1;
                        cfg_data     <= frag_backlog[0].cfg_val;
                        total_reg    = frag_backlog[0].cfg_val;
                        quiet_cycles = 0;
                        void'(frag_backlog.pop_front());
                    end
                end else if ($urandom_range(99) >= sender_gap_pct) begin
                    nxt_start = 1'b1;
                    frag      <= frag_backlog[0].f;
                end
            end
            start  <= hold ? 1'b1 : nxt_start;
            cfg_we <= nxt_we;
        end
    end

    // Monitor: every result transaction must match the oldest prediction
    always @(posedge clk) begin : check_events
        result_t want;
        if (rst_n && result_valid) begin
            if (pending_events.size() == 0) begin
                flag_error($sformatf("unexpected transaction kind=%0d seq=%0d",
                                     result.event_kind, result.event_seq));
            end else begin
                want = pending_events.pop_front();
                if (result !== want)
                    flag_error($sformatf(
                        "got kind=%0d seq=%0d len=%0d hnd=%0d exp=%0d last=%0d, want %0d %0d %0d %0d %0d %0d",
                        result.event_kind, result.event_seq, result.event_len,
                        result.event_handle, result.expected_now, result.last,
                        want.event_kind, want.event_seq, want.event_len,
                        want.event_handle, want.expected_now, want.last));
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((start && !busy) || result_valid || cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[fragment_reorder_receiver] ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned base;
        int unsigned win;
        int unsigned cap;
        int unsigned nb;
        int unsigned roll;
        int unsigned s;
        int unsigned stale_top;
        int unsigned done;
        logic [LEN_W-1:0] l;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, boundary reject, zero length, occupied slot
        queue_frag(16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_frag(16'd32, 16'd1, 16'd2);
        queue_frag(16'd5, 16'd0, 16'd0);
        queue_frag(16'd5, 16'd123, 16'd456);
        queue_frag(16'd3, 16'h8000, 16'h0001);
        queue_frag(16'd2, 16'h00FF, 16'hFF00);
        queue_frag(16'd1, 16'h5555, 16'hAAAA);
        queue_frag(16'd0, 16'hFFFF, 16'hFFFF);   // releases 1..3
        queue_frag(16'd2, 16'd7, 16'd7);         // stale
        queue_frag(16'd31, 16'hAAAA, 16'h5555);
        queue_frag(16'd4, 16'd1, 16'd0);         // releases the zero-length slot 5
        queue_total(6'd0);                       // window of one
        queue_frag(16'd0, 16'd9, 16'd9);
        queue_frag(16'd1, 16'd9, 16'd9);
        queue_total(6'd8);                       // shrinks below stored slot 31
        queue_frag(16'd7, 16'h1234, 16'h4321);
        queue_frag(16'd6, 16'h0F0F, 16'hF0F0);   // transfer complete at 8
        queue_frag(16'd31, 16'd3, 16'd3);
        queue_frag(16'd7, 16'd3, 16'd3);
        queue_total(6'd63);
        queue_frag(16'd8, 16'd8, 16'd8);

        // Random: mostly reports just ahead of the expected number, paced deliveries
        done = 0;
        for (int phase = 0; phase < 3; phase++) begin
            drain_backlog();
            sender_gap_pct = (phase == 0) ? 11 : (phase == 1) ? 45 : 0;
            queue_total((phase == 0) ? 6'd32 : (phase == 1) ? CFG_W'(next_seq + 8) : 6'd63);
            while (done < (phase + 1) * PHASE_ITEMS) begin
                drain_backlog();
                base = next_seq;
                win  = eff_total();
                cap  = DIRECTED_NEXT + done * 23 / RANDOM_ITEMS;
                stale_top = (base < win) ? base : win;
                nb = $urandom_range(8, 1);
                for (int i = 0; i < nb; i++) begin
                    roll = $urandom_range(99);
                    l = ($urandom_range(15) == 0) ? '0 : LEN_W'($urandom);
                    if (roll < 8 && stale_top > 0) begin
                        s = $urandom_range(stale_top - 1, 0);
                        done--;
                    end else if (roll < 20 || base + 1 >= win) begin
                        s = $urandom_range(65535, win);
                    end else if (roll < 32) begin
                        s = $urandom_range(win - 1, base + 1);
                    end else begin
                        s = base + 1 + $urandom_range((win - base - 2 < 5) ? win - base - 2 : 5, 0);
                    end
                    queue_frag(SEQ_W'(s), l, HANDLE_W'($urandom));
                    done++;
                end
                if (base < win && base <= cap && $urandom_range(1) == 0) begin
                    queue_frag(SEQ_W'(base), LEN_W'($urandom), HANDLE_W'($urandom));
                    done++;
                end
            end
        end

        drain_backlog();
        while (pending_events.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_events.size() != 0)
            flag_error($sformatf("%0d predicted transactions never arrived",
                                 pending_events.size()));
        if (err_count == 0)
            $display("[fragment_reorder_receiver] OK");
        else
            $display("[fragment_reorder_receiver] ERROR");
        $finish;
    end

endmodule
